// ===== rtl/core/vlce_pkg.sv =====
// Shared constants and types of the variable-length count encoder.
`default_nettype none

package vlce_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned TotalW = 23;
  localparam int unsigned LenW   = 6;            // code length, at most 62
  localparam int unsigned CodeW  = 2 * ValueW;   // left-aligned code field
  localparam int unsigned WinW   = WordW + CodeW;
  localparam int unsigned CntW   = $clog2(WordW);

  localparam logic [ValueW-1:0] ValueMax = {{(ValueW-2){1'b1}}, 2'b01};
  localparam logic [TotalW-1:0] TotalSat = {1'b1, {(TotalW-1){1'b0}}};

  localparam int unsigned QueueDepth = 2;

  // One classified count on its way from the front end to the packer.
  typedef struct packed {
    logic [CodeW-1:0] code;   // code bits, MSB first, zero filled below
    logic [LenW-1:0]  len;    // number of code bits
    logic             last;   // closes the vector
  } code_t;

endpackage

`default_nettype wire

// ===== rtl/core/variable_length_count_encoder.sv =====
// Top level of the variable-length count encoder (offset-two gamma code packer).
//
// Input channel: valid_i / stall_o carry one count per beat (marking_value_i)
// with last_value_i marking the final count of a vector. Counts above
// 2^32-3 are clamped. Each count v becomes t = v + 2 written in 2n bits,
// n = floor(log2(t)), packed MSB first into 32-bit words.
// Output channel: valid_o / stall_i carry one word per beat. Full words leave
// as they fill; the final word of a vector, zero padded, has last_word_o set
// and total_bits_o holds the vector's code length (saturating at 2^22).
// The packer takes the next item while the last word of the current one leaves;
// an ordinary item yields at most 2 words and a closing one 3, so the single-word
// output port sets the rate.
// A two-entry queue sits between the classifying front end and the packer,
// so input beats keep flowing while the output is stalled until it fills;
// a stalled output beat holds. Reset empties every stage and clears the
// pending word and the running bit count.
`default_nettype none

module variable_length_count_encoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [vlce_pkg::ValueW-1:0] marking_value_i,
  input  wire logic                        last_value_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [vlce_pkg::WordW-1:0]       packed_word_o,
  output logic                             last_word_o,
  output logic [vlce_pkg::TotalW-1:0]      total_bits_o
);

  logic            q_full;
  logic            q_valid;
  logic            push;
  logic            pop;
  vlce_pkg::code_t push_data;
  vlce_pkg::code_t pop_data;

  // Classify: clamp, offset, and left-align the code.
  vlce_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .marking_value_i (marking_value_i),
    .last_value_i    (last_value_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  // Decouple the two halves.
  vlce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // Pack and emit words.
  vlce_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .packed_word_o (packed_word_o),
    .last_word_o   (last_word_o),
    .total_bits_o  (total_bits_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vlce_front.sv =====
// Front end: accept counts, clamp, offset and turn them into left-aligned codes.
`default_nettype none

module vlce_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [vlce_pkg::ValueW-1:0] marking_value_i,
  input  wire logic                        last_value_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output vlce_pkg::code_t                  push_data_o
);

  logic                        s1_valid_q;
  logic [vlce_pkg::ValueW-1:0] s1_t_q;
  logic                        s1_last_q;
  logic                        accept;
  logic [vlce_pkg::ValueW-1:0] clamped;
  logic [vlce_pkg::LenW-2:0]   msb_pos;
  logic [vlce_pkg::LenW-1:0]   len;
  logic [vlce_pkg::CodeW-1:0]  code;

  assign stall_o = s1_valid_q && q_full_i;
  assign accept  = valid_i && !stall_o;
  assign push_o  = s1_valid_q && !q_full_i;

  assign clamped = (marking_value_i > vlce_pkg::ValueMax) ? vlce_pkg::ValueMax
                                                          : marking_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the offset count; clamp keeps t = v + 2 inside the value width.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_t_q    <= clamped + vlce_pkg::ValueW'(2);
      s1_last_q <= last_value_i;
    end
  end

  // Leading-one position of t gives n; the code is t written in 2n bits.
  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < vlce_pkg::ValueW; i++) begin
      if (s1_t_q[i]) begin
        msb_pos = (vlce_pkg::LenW-1)'(i);
      end
    end
  end

  assign len  = {msb_pos, 1'b0};
  assign code = {{(vlce_pkg::CodeW-vlce_pkg::ValueW){1'b0}}, s1_t_q}
                << (7'(vlce_pkg::CodeW) - {1'b0, len});

  assign push_data_o.code = code;
  assign push_data_o.len  = len;
  assign push_data_o.last = s1_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/vlce_queue.sv =====
// Two-entry queue that decouples the front end from the packer.
`default_nettype none

module vlce_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vlce_pkg::code_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output vlce_pkg::code_t      pop_data_o
);

  localparam int unsigned PtrW = $clog2(vlce_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(vlce_pkg::QueueDepth + 1);

  vlce_pkg::code_t entry_q [vlce_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(vlce_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(vlce_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(vlce_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vlce_back.sv =====
// Back end: pack codes into words, track the vector length, drive the output beat.
`default_nettype none

module vlce_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire vlce_pkg::code_t             q_data_i,
  output logic                             pop_o,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [vlce_pkg::WordW-1:0]       packed_word_o,
  output logic                             last_word_o,
  output logic [vlce_pkg::TotalW-1:0]      total_bits_o
);

  localparam int unsigned WordW  = vlce_pkg::WordW;
  localparam int unsigned WinW   = vlce_pkg::WinW;
  localparam int unsigned TotalW = vlce_pkg::TotalW;
  localparam int unsigned CntW   = vlce_pkg::CntW;

  // Packer state: unfinished word kept left aligned.
  logic [WordW-1:0]  pend_q;
  logic [CntW-1:0]   pc_q;
  logic [TotalW-1:0] total_q;

  // Words of the item in flight.
  logic [WinW-1:0]   win_q;
  logic [1:0]        rem_q;
  logic              fin_q;
  logic [TotalW-1:0] snap_q;

  // Output register.
  logic              out_valid_q;
  logic [WordW-1:0]  out_word_q;
  logic              out_last_q;
  logic [TotalW-1:0] out_total_q;

  logic              out_free;
  logic              emit;
  logic              final_word;
  logic [WinW-1:0]   win;
  logic [CntW+1:0]   fill;
  logic [1:0]        full_words;
  logic [CntW-1:0]   rest;
  logic [1:0]        nwords;
  logic [WordW-1:0]  tail;
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] total_new;

  assign out_free   = !out_valid_q || !stall_i;
  assign emit       = (rem_q != 2'd0) && out_free;
  assign final_word = fin_q && (rem_q == 2'd1);
  assign pop_o      = q_valid_i && ((rem_q == 2'd0) || ((rem_q == 2'd1) && emit));

  // Append the new code behind the pending bits.
  assign win  = {pend_q, {(WinW-WordW){1'b0}}}
              | ({q_data_i.code, {WordW{1'b0}}} >> pc_q);
  assign fill = (CntW+2)'(pc_q) + (CntW+2)'(q_data_i.len);
  assign full_words = fill[CntW+1:CntW];
  assign rest       = fill[CntW-1:0];

  always_comb begin
    case (full_words)
      2'd0:    tail = win[WinW-1 -: WordW];
      2'd1:    tail = win[WinW-1-WordW -: WordW];
      default: tail = win[WinW-1-2*WordW -: WordW];
    endcase
  end

  // A closing item whose code ends on a word boundary reuses that word as final.
  always_comb begin
    if (!q_data_i.last) begin
      nwords = full_words;
    end else if ((rest == '0) && (full_words != 2'd0)) begin
      nwords = full_words;
    end else begin
      nwords = full_words + 2'd1;
    end
  end

  assign sum       = {1'b0, total_q} + (TotalW+1)'(q_data_i.len);
  assign total_new = (sum > {1'b0, vlce_pkg::TotalSat}) ? vlce_pkg::TotalSat
                                                         : sum[TotalW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      pc_q        <= '0;
      total_q     <= '0;
      rem_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rem_q <= nwords;
        if (q_data_i.last) begin
          pend_q  <= '0;
          pc_q    <= '0;
          total_q <= '0;
        end else begin
          pend_q  <= tail;
          pc_q    <= rest;
          total_q <= total_new;
        end
      end else if (emit) begin
        rem_q <= rem_q - 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_q  <= win;
      fin_q  <= q_data_i.last;
      snap_q <= total_new;
    end else if (emit) begin
      win_q <= win_q << WordW;
    end
    if (emit) begin
      out_word_q  <= win_q[WinW-1 -: WordW];
      out_last_q  <= final_word;
      out_total_q <= final_word ? snap_q : '0;
    end
  end

  assign valid_o       = out_valid_q;
  assign packed_word_o = out_word_q;
  assign last_word_o   = out_last_q;
  assign total_bits_o  = out_total_q;

endmodule

`default_nettype wire
